### src/odst_pkg.sv
// Package for the ordered date set table.
// Holds sizes, command and status codes, item structs and cell control struct.
// No dependencies.
package odst_pkg;

  localparam int CAPACITY = 512;
  localparam int GROUP    = 16;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int INDEX_W  = 9;
  localparam int COUNT_W  = 10;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int KEY_W    = MONTH_W + DAY_W;
  localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

### src/ordered_date_set_table_top.sv
// Top level of the ordered date set table: control, cell chain, group
// reduction and output register.
// Depends on odst_pkg and odst_cell.
//
//   channel | signals                       | moves
//   --------+-------------------------------+---------------------------
//   input   | in_valid, in_ready, in_item   | command with date / index
//   output  | out_valid, out_ready, out_item| status, found, date, count
//
// Each item passes accept, then compare across all cells (group results
// registered), then commit of add / remove shift and the result.
// The commit waits while the previous result is still held in the output register.
// Reset clears the count, the state and out_valid; cell contents are kept.
// in_ready is high only while no item is in progress.
module ordered_date_set_table_top import odst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t             state;
  cmd_t               cmd;
  logic [KEY_W-1:0]   key;
  logic [INDEX_W-1:0] idx;
  logic [CNT_W-1:0]   held_count;

  logic [KEY_W-1:0]   ent [CAPACITY];
  cell_ctrl_t         ctrl [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] sel;
  logic [CAPACITY-1:0] mreg;
  logic [CAPACITY-1:0] pre;

  logic [NGROUP-1:0]  g_hit_next;
  logic [KEY_W-1:0]   g_rd_next [NGROUP];
  logic [NGROUP-1:0]  g_hit;
  logic [KEY_W-1:0]   g_rd [NGROUP];

  logic               found;
  logic [KEY_W-1:0]   rd;
  logic               full;
  logic               rd_ok;
  logic               commit;
  logic               do_add;
  logic               do_rem;
  out_item_t          out_item_next;

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_FIN) && (!out_valid || out_ready);
  assign full     = (held_count >= CNT_W'(CAPACITY));
  assign rd_ok    = (CMP_W'(idx) < CMP_W'(held_count));
  assign do_add   = commit && (cmd == CMD_ADD) && !found && !full;
  assign do_rem   = commit && (cmd == CMD_REMOVE) && found;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] nxt;
    if (i == CAPACITY - 1) begin : g_last
      assign nxt = ent[i];
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    assign sel[i]        = (CMP_W'(idx) == CMP_W'(i));
    assign ctrl[i].load  = do_add && (held_count == CNT_W'(i));
    assign ctrl[i].shift = do_rem && pre[i];
    odst_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .key       (key),
      .from_next (nxt),
      .pos       (CNT_W'(i)),
      .count     (held_count),
      .entry     (ent[i]),
      .match     (match[i])
    );
  end

  // per-group match and read data
  always_comb begin
    int c;
    for (int g = 0; g < NGROUP; g++) begin
      g_hit_next[g] = 1'b0;
      g_rd_next[g]  = '0;
      for (int j = 0; j < GROUP; j++) begin
        c = g * GROUP + j;
        if (c < CAPACITY) begin
          g_hit_next[g] = g_hit_next[g] | match[c];
          g_rd_next[g]  = g_rd_next[g] | (sel[c] ? ent[c] : '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      mreg  <= match;
      g_hit <= g_hit_next;
      g_rd  <= g_rd_next;
    end
  end

  // found, read data and shift prefix from registered group results
  always_comb begin
    logic prior;
    logic run;
    int   c;
    found = |g_hit;
    rd    = '0;
    prior = 1'b0;
    pre   = '0;
    for (int g = 0; g < NGROUP; g++) begin
      rd  = rd | g_rd[g];
      run = prior;
      for (int j = 0; j < GROUP; j++) begin
        c = g * GROUP + j;
        if (c < CAPACITY) begin
          run    = run | mreg[c];
          pre[c] = run;
        end
      end
      prior = prior | g_hit[g];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= in_item.cmd;
      key <= {in_item.month, in_item.day_of_month};
      idx <= in_item.index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_SCAN;
        S_SCAN: state <= S_FIN;
        S_FIN:  if (commit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (do_add) begin
        held_count <= held_count + CNT_W'(1);
      end else if (do_rem) begin
        held_count <= held_count - CNT_W'(1);
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    out_item_next        = '0;
    out_item_next.status = ST_OK;
    out_item_next.count  = COUNT_W'(held_count);
    case (cmd)
      CMD_ADD: begin
        out_item_next.found = found;
        if (!found && full) begin
          out_item_next.status = ST_FULL;
        end else if (!found) begin
          out_item_next.count = COUNT_W'(held_count + CNT_W'(1));
        end
      end
      CMD_REMOVE: begin
        out_item_next.found = found;
        if (found) begin
          out_item_next.count = COUNT_W'(held_count - CNT_W'(1));
        end
      end
      CMD_QUERY: out_item_next.found = found;
      CMD_READ: begin
        if (rd_ok) begin
          out_item_next.out_month = rd[KEY_W-1:DAY_W];
          out_item_next.out_day   = rd[DAY_W-1:0];
        end else begin
          out_item_next.status = ST_RANGE;
        end
      end
      default: out_item_next.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_item <= out_item_next;
    end
  end

endmodule

### src/odst_cell.sv
// One storage cell of the date chain: holds one entry, compares it with the
// broadcast key, loads the key or takes its upper neighbour's entry.
// Depends on odst_pkg.
module odst_cell import odst_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] key,
  input  logic [KEY_W-1:0] from_next,
  input  logic [CNT_W-1:0] pos,
  input  logic [CNT_W-1:0] count,
  output logic [KEY_W-1:0] entry,
  output logic             match
);

  assign match = (pos < count) && (entry == key);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= key;
    end else if (ctrl.shift) begin
      entry <= from_next;
    end
  end

endmodule

### src/odst_checker.sv
// Port-level checks for the ordered date set table, bound to the top level.
// Depends on odst_pkg and ordered_date_set_table_top.
module odst_checker import odst_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == ST_FULL) |->
      !out_item.found && (out_item.count == COUNT_W'(CAPACITY)))
    else $error("full status without full store");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == ST_RANGE) |->
      (out_item.out_month == '0) && (out_item.out_day == '0) && !out_item.found)
    else $error("out of range read returned data");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

endmodule

bind ordered_date_set_table_top odst_checker u_odst_checker (.*);

### dv/tb_ordered_date_set_table_top.sv
// Testbench for ordered_date_set_table_top: random and directed date commands
// checked against an in-bench model of the ordered date store.
// Depends on odst_pkg and the RTL under src.
module tb_ordered_date_set_table_top;
  import odst_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int CALM_ITEMS   = 250;
  localparam int HOT_KEYS     = 24;

  typedef struct {
    in_item_t item;
    bit       hold_for_drain;
  } pending_cmd_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  pending_cmd_t cmd_q[$];
  pending_cmd_t head_cmd;
  out_item_t    expected_q[$];
  int           waiting = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  bit           calm = 1'b0;
  int           fail_count = 0;
  int           cycles = 0;

  logic [KEY_W-1:0] date_store [CAPACITY];
  int               held = 0;
  logic [KEY_W-1:0] hot [HOT_KEYS];

  ordered_date_set_table_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic out_item_t predict_date_cmd(in_item_t it);
    out_item_t        r;
    logic [KEY_W-1:0] key;
    int               pos;
    r   = '0;
    key = {it.month, it.day_of_month};
    pos = -1;
    for (int i = 0; i < held; i++) begin
      if (pos < 0 && date_store[i] == key) pos = i;
    end
    case (it.cmd)
      CMD_ADD: begin
        if (pos >= 0) r.found = 1'b1;
        else if (held >= CAPACITY) r.status = ST_FULL;
        else begin
          date_store[held] = key;
          held++;
        end
      end
      CMD_REMOVE: begin
        if (pos >= 0) begin
          r.found = 1'b1;
          for (int i = pos + 1; i < held; i++) date_store[i-1] = date_store[i];
          held--;
        end
      end
      CMD_QUERY: r.found = (pos >= 0);
      default: begin
        if (int'(it.index) < held) begin
          r.out_month = date_store[it.index][KEY_W-1:DAY_W];
          r.out_day   = date_store[it.index][DAY_W-1:0];
        end else begin
          r.status = ST_RANGE;
        end
      end
    endcase
    r.count = COUNT_W'(held);
    return r;
  endfunction

  task automatic check_result(out_item_t got, out_item_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      fail_count++;
    end
    if (got.out_month !== want.out_month) begin
      $error("out_month: expected %0d, got %0d", want.out_month, got.out_month);
      fail_count++;
    end
    if (got.out_day !== want.out_day) begin
      $error("out_day: expected %0d, got %0d", want.out_day, got.out_day);
      fail_count++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      fail_count++;
    end
  endtask

  task automatic push_cmd(cmd_t c, logic [KEY_W-1:0] key, int idx, bit drain = 1'b0);
    pending_cmd_t p;
    p.item.cmd          = c;
    p.item.month        = key[KEY_W-1:DAY_W];
    p.item.day_of_month = key[DAY_W-1:0];
    p.item.index        = INDEX_W'(idx);
    p.hold_for_drain    = drain;
    cmd_q.push_back(p);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) != 0) return hot[$urandom_range(0, HOT_KEYS - 1)];
    return KEY_W'($urandom_range(0, 511));
  endfunction

  function automatic int pick_index();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 511);
    return $urandom_range(0, 31);
  endfunction

  task automatic push_mixed(int n, bit drain_first);
    for (int i = 0; i < n; i++) begin
      push_cmd(cmd_t'($urandom_range(0, 3)), pick_key(), pick_index(),
               drain_first && i == 0);
    end
  endtask

  task automatic push_fill_and_drain();
    int order [512];
    int j;
    int t;
    for (int i = 0; i < 512; i++) order[i] = i;
    for (int i = 511; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    // every key once in random order, so the store ends full
    for (int i = 0; i < 512; i++) begin
      if ($urandom_range(0, 7) == 0) push_cmd(CMD_READ, '0, pick_index(), i == 0);
      push_cmd(CMD_ADD, KEY_W'(order[i]), $urandom_range(0, 511), i == 0);
    end
    for (int i = 0; i < 50; i++) begin
      case ($urandom_range(0, 2))
        0: push_cmd(CMD_ADD, KEY_W'($urandom_range(0, 511)), 0);
        1: push_cmd(CMD_QUERY, KEY_W'($urandom_range(0, 511)), 0);
        default: push_cmd(CMD_READ, '0, $urandom_range(0, 511));
      endcase
    end
    push_cmd(CMD_READ, '0, 511);
    push_cmd(CMD_READ, '0, 0);
    for (int i = 0; i < 300; i++) begin
      push_cmd(CMD_REMOVE, KEY_W'($urandom_range(0, 511)), 0);
      if ($urandom_range(0, 4) == 0) push_cmd(CMD_READ, '0, $urandom_range(0, 511));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      calm     <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0 && cmd_q[0].hold_for_drain &&
                   (waiting != 0 || (in_valid && in_ready))) begin
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        head_cmd = cmd_q.pop_front();
        in_item  <= head_cmd.item;
        in_valid <= 1'b1;
        calm     <= (cmd_q.size() < CALM_ITEMS);
        if (!calm && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and result check
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      waiting    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with none expected: status %0d count %0d",
                 out_item.status, out_item.count);
          fail_count++;
        end else begin
          check_result(out_item, expected_q.pop_front());
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_date_cmd(in_item));
      waiting <= expected_q.size();
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 18) - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < HOT_KEYS; i++) hot[i] = KEY_W'($urandom_range(0, 511));

    // directed: empty store, duplicates, field extremes, shift on remove
    push_cmd(CMD_READ,   '0, 0);
    push_cmd(CMD_READ,   '0, 511);
    push_cmd(CMD_REMOVE, {4'd1, 5'd1}, 0);
    push_cmd(CMD_QUERY,  {4'd1, 5'd1}, 0);
    push_cmd(CMD_ADD,    {4'd1, 5'd1}, 0);
    push_cmd(CMD_ADD,    {4'd1, 5'd1}, 0);
    push_cmd(CMD_ADD,    {4'd12, 5'd31}, 511);
    push_cmd(CMD_ADD,    {4'd0, 5'd0}, 0);
    push_cmd(CMD_ADD,    {4'd15, 5'd31}, 0);
    push_cmd(CMD_QUERY,  {4'd12, 5'd31}, 0);
    push_cmd(CMD_QUERY,  {4'd12, 5'd30}, 0);
    push_cmd(CMD_READ,   '0, 0);
    push_cmd(CMD_READ,   '0, 1);
    push_cmd(CMD_READ,   '0, 2);
    push_cmd(CMD_READ,   '0, 3);
    push_cmd(CMD_READ,   '0, 4);
    push_cmd(CMD_REMOVE, {4'd1, 5'd1}, 0);
    push_cmd(CMD_READ,   '0, 0);
    push_cmd(CMD_QUERY,  {4'd1, 5'd1}, 0);
    push_cmd(CMD_REMOVE, {4'd0, 5'd0}, 0);
    push_cmd(CMD_READ,   '0, 1);
    push_cmd(CMD_ADD,    {4'd7, 5'd15}, 0);
    push_cmd(CMD_READ,   '0, 2);
    push_cmd(CMD_REMOVE, {4'd15, 5'd31}, 0);
    push_cmd(CMD_READ,   '0, 2);

    push_mixed(190, 1'b1);
    for (int i = 0; i < 512; i++) push_cmd(CMD_REMOVE, KEY_W'(i), 0);
    push_fill_and_drain();
    push_mixed(190, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (cmd_q.size() == 0 && !in_valid);
    @(posedge clk);
    wait (waiting == 0);
    repeat (12) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected result items never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
